// ===== rtl/core/npvd_pkg.sv =====
// Shared types and constants of the nearest point value difference block.
// Used by npvd_sq_unit, npvd_store and nearest_point_value_difference.
// No dependencies.
package npvd_pkg;

	localparam int MAX_POINTS_DEF = 1024;

	localparam int COUNT_W = 11;
	localparam int INDEX_W = 10;
	localparam int COORD_W = 32;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int SQ_W    = 2 * COORD_W + 1;
	localparam int DIST_W  = SQ_W + 1;

	localparam int IN_DATA_W  = 176;
	localparam int OUT_DATA_W = 48;

	localparam int IN_INDEX_LSB  = 0;
	localparam int IN_X_LSB      = IN_INDEX_LSB + INDEX_W;
	localparam int IN_Y_LSB      = IN_X_LSB + COORD_W;
	localparam int IN_Z_LSB      = IN_Y_LSB + COORD_W;
	localparam int IN_FIRST_LSB  = IN_Z_LSB + COORD_W;
	localparam int IN_SECOND_LSB = IN_FIRST_LSB + COORD_W;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic signed [COORD_W-1:0] second;
		logic signed [COORD_W-1:0] first;
		logic signed [COORD_W-1:0] z;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} point_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_READ = 5'b00010,
		ST_CALC = 5'b00100,
		ST_CMP  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

endpackage

// ===== rtl/core/npvd_sq_unit.sv =====
// Shared squared-difference unit: subtracts two signed coordinates and
// squares the magnitude, with the product registered. Uses npvd_pkg.
module npvd_sq_unit (
	input  logic                                 clk,
	input  logic signed [npvd_pkg::COORD_W-1:0]  a,
	input  logic signed [npvd_pkg::COORD_W-1:0]  b,
	output logic        [npvd_pkg::SQ_W-1:0]     sq_q
);

	logic signed [npvd_pkg::DIFF_W-1:0]   diff;
	logic        [npvd_pkg::DIFF_W-1:0]   mag;
	logic        [2*npvd_pkg::DIFF_W-1:0] full;

	assign diff = npvd_pkg::DIFF_W'(a) - npvd_pkg::DIFF_W'(b);
	assign mag  = diff[npvd_pkg::DIFF_W-1] ? npvd_pkg::DIFF_W'(-diff) : npvd_pkg::DIFF_W'(diff);
	assign full = {{npvd_pkg::DIFF_W{1'b0}}, mag} * {{npvd_pkg::DIFF_W{1'b0}}, mag};

	always_ff @(posedge clk) begin
		sq_q <= npvd_pkg::SQ_W'(full);
	end

endmodule

// ===== rtl/core/npvd_store.sv =====
// Reference point store: one write port and one registered read port.
// Each word holds a whole point_t from npvd_pkg.
module npvd_store #(
	parameter int DEPTH  = npvd_pkg::MAX_POINTS_DEF,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [ADDR_W-1:0]     wr_addr,
	input  npvd_pkg::point_t      wr_data,
	input  logic [ADDR_W-1:0]     rd_addr,
	output npvd_pkg::point_t      rd_data_q
);

	npvd_pkg::point_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

endmodule

// ===== rtl/core/nearest_point_value_difference.sv =====
// Top level of the nearest point value difference block: sequencer,
// accumulator and best-point tracking. Uses npvd_pkg, npvd_store, npvd_sq_unit.
//
// Usage. The cfg channel (cfg_valid, cfg_ready, cfg_data) writes point_count;
// cfg_ready is always high; the user must make writes only while the block is
// idle, which the block itself does not enforce. The slave stream carries one
// transaction per item; s_tuser is the opcode. A load writes one store slot
// if its entry_index is below MAX_POINTS. A query scans slots 0 .. point_count-1
// (at most MAX_POINTS) and returns one transaction on the master stream:
// found in m_tuser, slot and value difference in m_tdata. For each slot
// searched, the shared squaring multiplier takes x, y and z in turn; the
// squares are accumulated and the sum is compared with the best so far.
// s_tready is high only while no query is in progress.
// A finished result sits in the output register until taken; loads are
// accepted meanwhile, and a following query holds its result back until
// the receiver takes the one before it.
// Reset clears point_count and all control state; store contents are
// undefined until written, so only loaded slots may be searched.
module nearest_point_value_difference #(
	parameter int MAX_POINTS = npvd_pkg::MAX_POINTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [npvd_pkg::COUNT_W-1:0]       cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// Fields from bit 0: entry_index, coord_x, coord_y, coord_z,
	// value_first, value_second, zero fill.
	input  logic [npvd_pkg::IN_DATA_W-1:0]     s_tdata,
	// Fields from bit 0: opcode.
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// Fields from bit 0: nearest_index, difference, zero fill.
	output logic [npvd_pkg::OUT_DATA_W-1:0]    m_tdata,
	// Fields from bit 0: found.
	output logic                               m_tuser
);

	localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);

	npvd_pkg::state_t                  state_q;
	logic [npvd_pkg::COUNT_W-1:0]      point_count_q;
	logic [CNT_W-1:0]                  n_q;
	logic [CNT_W-1:0]                  idx_q;
	logic [1:0]                        phase_q;
	logic                              found_q;

	logic signed [npvd_pkg::COORD_W-1:0] qx_q, qy_q, qz_q;
	logic [npvd_pkg::DIST_W-1:0]       acc_q;
	logic [npvd_pkg::DIST_W-1:0]       best_dist_q;
	logic [CNT_W-1:0]                  best_idx_q;
	logic signed [npvd_pkg::COORD_W-1:0] best_first_q, best_second_q;

	logic                              out_found_q;
	logic [npvd_pkg::INDEX_W-1:0]      out_index_q;
	logic signed [npvd_pkg::DIFF_W-1:0] out_diff_q;
	logic                              m_tvalid_q;

	logic                              in_fire;
	logic                              load_fire;
	logic                              query_fire;
	logic                              in_range;
	logic                              out_load;
	logic                              update;
	logic                              last;
	logic [CNT_W-1:0]                  n_next;
	logic [ADDR_W-1:0]                 rd_addr;
	npvd_pkg::point_t                  wr_point;
	npvd_pkg::point_t                  rd_point;
	logic signed [npvd_pkg::COORD_W-1:0] sel_p, sel_q;
	logic [npvd_pkg::SQ_W-1:0]         sq;
	logic [npvd_pkg::INDEX_W-1:0]      in_index;

	assign cfg_ready  = 1'b1;
	assign s_tready   = (state_q == npvd_pkg::ST_IDLE);
	assign in_fire    = s_tvalid && s_tready;
	assign load_fire  = in_fire && (s_tuser == npvd_pkg::OP_LOAD) && in_range;
	assign query_fire = in_fire && (s_tuser == npvd_pkg::OP_QUERY);
	assign in_index   = s_tdata[npvd_pkg::IN_INDEX_LSB +: npvd_pkg::INDEX_W];
	assign in_range   = (32'(in_index) < 32'(MAX_POINTS));
	assign n_next     = (32'(point_count_q) > 32'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
	                                                          : CNT_W'(point_count_q);
	assign out_load   = (state_q == npvd_pkg::ST_DONE) && (!m_tvalid_q || m_tready);
	assign update     = (idx_q == '0) || (acc_q <= best_dist_q);
	assign last       = ((idx_q + CNT_W'(1)) == n_q);
	assign rd_addr    = (state_q == npvd_pkg::ST_CMP) ? ADDR_W'(idx_q + CNT_W'(1))
	                                                  : ADDR_W'(idx_q);

	assign wr_point.x      = s_tdata[npvd_pkg::IN_X_LSB +: npvd_pkg::COORD_W];
	assign wr_point.y      = s_tdata[npvd_pkg::IN_Y_LSB +: npvd_pkg::COORD_W];
	assign wr_point.z      = s_tdata[npvd_pkg::IN_Z_LSB +: npvd_pkg::COORD_W];
	assign wr_point.first  = s_tdata[npvd_pkg::IN_FIRST_LSB +: npvd_pkg::COORD_W];
	assign wr_point.second = s_tdata[npvd_pkg::IN_SECOND_LSB +: npvd_pkg::COORD_W];

	npvd_store #(
		.DEPTH  (MAX_POINTS),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk       (clk),
		.wr_en     (load_fire),
		.wr_addr   (ADDR_W'(in_index)),
		.wr_data   (wr_point),
		.rd_addr   (rd_addr),
		.rd_data_q (rd_point)
	);

	always_comb begin
		case (phase_q)
			2'd0: begin
				sel_p = rd_point.x;
				sel_q = qx_q;
			end
			2'd1: begin
				sel_p = rd_point.y;
				sel_q = qy_q;
			end
			default: begin
				sel_p = rd_point.z;
				sel_q = qz_q;
			end
		endcase
	end

	npvd_sq_unit u_sq (
		.clk  (clk),
		.a    (sel_p),
		.b    (sel_q),
		.sq_q (sq)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= npvd_pkg::ST_IDLE;
			point_count_q <= '0;
			n_q           <= '0;
			idx_q         <= '0;
			phase_q       <= '0;
			found_q       <= 1'b0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				point_count_q <= cfg_data;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				npvd_pkg::ST_IDLE: begin
					if (query_fire) begin
						n_q     <= n_next;
						idx_q   <= '0;
						found_q <= (n_next != '0);
						state_q <= (n_next != '0) ? npvd_pkg::ST_READ : npvd_pkg::ST_DONE;
					end
				end
				npvd_pkg::ST_READ: begin
					phase_q <= '0;
					state_q <= npvd_pkg::ST_CALC;
				end
				npvd_pkg::ST_CALC: begin
					phase_q <= phase_q + 2'd1;
					if (phase_q == 2'd3) begin
						state_q <= npvd_pkg::ST_CMP;
					end
				end
				npvd_pkg::ST_CMP: begin
					idx_q   <= idx_q + CNT_W'(1);
					phase_q <= '0;
					state_q <= last ? npvd_pkg::ST_DONE : npvd_pkg::ST_CALC;
				end
				npvd_pkg::ST_DONE: begin
					if (out_load) begin
						state_q <= npvd_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= npvd_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (query_fire) begin
			qx_q <= s_tdata[npvd_pkg::IN_X_LSB +: npvd_pkg::COORD_W];
			qy_q <= s_tdata[npvd_pkg::IN_Y_LSB +: npvd_pkg::COORD_W];
			qz_q <= s_tdata[npvd_pkg::IN_Z_LSB +: npvd_pkg::COORD_W];
		end
		if (state_q == npvd_pkg::ST_CALC) begin
			if (phase_q == 2'd1) begin
				acc_q <= npvd_pkg::DIST_W'(sq);
			end else if (phase_q != 2'd0) begin
				acc_q <= acc_q + npvd_pkg::DIST_W'(sq);
			end
		end
		if ((state_q == npvd_pkg::ST_CMP) && update) begin
			best_dist_q   <= acc_q;
			best_idx_q    <= idx_q;
			best_first_q  <= rd_point.first;
			best_second_q <= rd_point.second;
		end
		if (out_load) begin
			out_found_q <= found_q;
			if (found_q) begin
				out_index_q <= npvd_pkg::INDEX_W'(best_idx_q);
				out_diff_q  <= npvd_pkg::DIFF_W'(best_first_q) - npvd_pkg::DIFF_W'(best_second_q);
			end else begin
				out_index_q <= '0;
				out_diff_q  <= '0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_found_q;
	assign m_tdata  = {{(npvd_pkg::OUT_DATA_W - npvd_pkg::INDEX_W - npvd_pkg::DIFF_W){1'b0}},
	                   out_diff_q, out_index_q};

`ifndef SYNTHESIS
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == npvd_pkg::ST_CALC) |-> (idx_q < n_q))
		else $error("Scan index passed the search count.");

	a_cmp_after_calc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == npvd_pkg::ST_CMP) |->
			($past(state_q) == npvd_pkg::ST_CALC) && ($past(phase_q) == 2'd3))
		else $error("Compare entered before all three squares were summed.");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("Empty search returned a nonzero index or difference.");

	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (m_tvalid && (state_q == npvd_pkg::ST_IDLE)))
		else $error("Finished query did not reach the output register.");
`endif

endmodule
